/* rtl/core/palette_section_fade_defines.svh */
// assertion macros for the palette section fade checker
// no dependencies; expects aclk and aresetn in the scope of use
`ifndef PALETTE_SECTION_FADE_DEFINES_SVH
`define PALETTE_SECTION_FADE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PSF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PSF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/psf_pkg.sv */
// types, widths and constants shared by the palette section fade block
// no dependencies
package psf_pkg;

    localparam int TIME_W    = 32;
    localparam int PERIOD_W  = 16;
    localparam int COUNT_W   = 5;
    localparam int SECLEN_W  = 8;
    localparam int PIXEL_W   = 10;
    localparam int CHAN_W    = 8;
    localparam int ENTRY_W   = 4;
    localparam int SECIDX_W  = 6;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 16;
    localparam int COLOR_W   = 3 * CHAN_W;

    localparam int DIV_NUM_W = 24;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [PERIOD_W-1:0] PERIOD_ZERO_MS = 16'd50;
    localparam logic [CHAN_W-1:0]   FRACTION_TOP   = 8'd255;

    localparam logic [PERIOD_W-1:0] RST_PERIOD = 16'd50;
    localparam logic [COUNT_W-1:0]  RST_COUNT  = 5'd1;
    localparam logic [SECLEN_W-1:0] RST_SECLEN = 8'd0;
    localparam logic [PIXEL_W-1:0]  RST_PIXELS = 10'd64;

    typedef enum logic [CFG_AW-1:0] {
        REG_PERIOD,
        REG_COUNT,
        REG_SECLEN,
        REG_PIXELS
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ELAPSED,
        ST_NSEC_GO,
        ST_NSEC_WAIT,
        ST_FRAC_GO,
        ST_FRAC_WAIT,
        ST_PHASE_GO,
        ST_PHASE_WAIT,
        ST_READ,
        ST_MIX,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DIV_NSEC,
        DIV_FRAC,
        DIV_PHASE
    } div_op_t;

    typedef struct packed {
        logic    accept_tick;
        logic    write_pal;
        logic    eval_elapsed;
        logic    div_start;
        div_op_t div_op;
        logic    cap_nsec;
        logic    cap_frac;
        logic    cap_phase;
        logic    read_pal;
        logic    load_out;
        logic    advance;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic nsec_zero;
        logic last_sec;
    } dp_status_t;

endpackage

/* rtl/core/psf_div.sv */
// iterative restoring divider, one quotient bit per cycle
// depends on psf_pkg
module psf_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [psf_pkg::DIV_NUM_W-1:0]  num_in,
    input  logic [psf_pkg::DIV_DEN_W-1:0]  den_in,
    output logic [psf_pkg::DIV_NUM_W-1:0]  quo_out,
    output logic [psf_pkg::DIV_DEN_W-1:0]  rem_out,
    output logic                           done
);
    import psf_pkg::*;

    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0] shifted;
    logic [DIV_DEN_W:0] trial;
    logic               fits;

    always_comb begin
        shifted = {rem_reg, quo_reg[DIV_NUM_W-1]};
        trial   = shifted - {1'b0, den_reg};
        fits    = !trial[DIV_DEN_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num_in;
            rem_reg <= '0;
            den_reg <= den_in;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end
    end

    assign quo_out = quo_reg;
    assign rem_out = rem_reg;
    assign done    = done_reg;

endmodule

/* rtl/core/psf_ctrl.sv */
// controller state machine: takes palette writes and sequences one tick through divisions and sections
// depends on psf_pkg
module psf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_cmd,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output psf_pkg::ctrl_cmd_t  cmd,
    input  psf_pkg::dp_status_t status
);
    import psf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_cmd == CMD_TICK) begin
                    state_next = ST_ELAPSED;
                end
            end
            ST_ELAPSED:    state_next = ST_NSEC_GO;
            ST_NSEC_GO:    state_next = ST_NSEC_WAIT;
            ST_NSEC_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_FRAC_GO;
                end
            end
            ST_FRAC_GO:    state_next = ST_FRAC_WAIT;
            ST_FRAC_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_PHASE_GO;
                end
            end
            ST_PHASE_GO:   state_next = ST_PHASE_WAIT;
            ST_PHASE_WAIT: begin
                if (status.div_done) begin
                    state_next = status.nsec_zero ? ST_IDLE : ST_READ;
                end
            end
            ST_READ:       state_next = ST_MIX;
            ST_MIX:        state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) begin
                    state_next = status.last_sec ? ST_IDLE : ST_READ;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready          = (state_reg == ST_IDLE);
        m_valid          = (state_reg == ST_OUT);
        cmd              = '0;
        cmd.div_op       = DIV_NSEC;
        cmd.accept_tick  = (state_reg == ST_IDLE) && s_valid && (s_cmd == CMD_TICK);
        cmd.write_pal    = (state_reg == ST_IDLE) && s_valid && (s_cmd == CMD_WRITE);
        cmd.eval_elapsed = (state_reg == ST_ELAPSED);
        unique case (state_reg)
            ST_NSEC_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_NSEC;
            end
            ST_FRAC_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_FRAC;
            end
            ST_PHASE_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_PHASE;
            end
            default: begin
                cmd.div_start = 1'b0;
            end
        endcase
        cmd.cap_nsec  = (state_reg == ST_NSEC_WAIT) && status.div_done;
        cmd.cap_frac  = (state_reg == ST_FRAC_WAIT) && status.div_done;
        cmd.cap_phase = (state_reg == ST_PHASE_WAIT) && status.div_done;
        cmd.read_pal  = (state_reg == ST_READ);
        cmd.load_out  = (state_reg == ST_MIX);
        cmd.advance   = (state_reg == ST_OUT) && m_ready;
    end

endmodule

/* rtl/core/psf_dp.sv */
// datapath: registers, palette memory, phase and time state, blend and outputs
// depends on psf_pkg and psf_div
module psf_dp #(
    parameter int MAX_SECTIONS           = 64,
    parameter int PALETTE_DEPTH          = 16,
    parameter int DEFAULT_SECTION_LENGTH = 3
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [psf_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [psf_pkg::CFG_DW-1:0]     cfg_wdata,
    input  logic [psf_pkg::TIME_W-1:0]     s_now_ms,
    input  logic [psf_pkg::ENTRY_W-1:0]    s_entry_index,
    input  logic [psf_pkg::CHAN_W-1:0]     s_red_in,
    input  logic [psf_pkg::CHAN_W-1:0]     s_green_in,
    input  logic [psf_pkg::CHAN_W-1:0]     s_blue_in,
    input  psf_pkg::ctrl_cmd_t             cmd,
    output psf_pkg::dp_status_t            status,
    output logic [psf_pkg::SECIDX_W-1:0]   m_section_index,
    output logic [psf_pkg::PIXEL_W-1:0]    m_first_pixel,
    output logic [psf_pkg::CHAN_W-1:0]     m_red,
    output logic [psf_pkg::CHAN_W-1:0]     m_green,
    output logic [psf_pkg::CHAN_W-1:0]     m_blue,
    output logic                           m_last
);
    import psf_pkg::*;

    localparam int PAL_AW = $clog2(PALETTE_DEPTH);
    localparam int PAL_CW = $clog2(PALETTE_DEPTH + 1);
    localparam int NSEC_W = $clog2(MAX_SECTIONS + 1);

    function automatic logic [CHAN_W-1:0] mix_chan(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b,
                                                   input logic [CHAN_W-1:0] f);
        logic [CHAN_W-1:0]   diff_up;
        logic [CHAN_W-1:0]   diff_dn;
        logic [2*CHAN_W-1:0] prod_up;
        logic [2*CHAN_W-1:0] prod_dn;
        logic [2*CHAN_W:0]   dn_round;
        diff_up  = b - a;
        diff_dn  = a - b;
        prod_up  = {{CHAN_W{1'b0}}, diff_up} * {{CHAN_W{1'b0}}, f};
        prod_dn  = {{CHAN_W{1'b0}}, diff_dn} * {{CHAN_W{1'b0}}, f};
        dn_round = {1'b0, prod_dn} + (2*CHAN_W+1)'(255);
        if (b >= a) begin
            return a + prod_up[2*CHAN_W-1:CHAN_W];
        end
        return a - dn_round[2*CHAN_W-1:CHAN_W];
    endfunction

    // configuration registers
    logic [PERIOD_W-1:0] period_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [SECLEN_W-1:0] seclen_reg;
    logic [PIXEL_W-1:0]  pixels_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= RST_PERIOD;
            count_reg  <= RST_COUNT;
            seclen_reg <= RST_SECLEN;
            pixels_reg <= RST_PIXELS;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_PERIOD: period_reg <= cfg_wdata[PERIOD_W-1:0];
                REG_COUNT:  count_reg  <= cfg_wdata[COUNT_W-1:0];
                REG_SECLEN: seclen_reg <= cfg_wdata[SECLEN_W-1:0];
                REG_PIXELS: pixels_reg <= cfg_wdata[PIXEL_W-1:0];
            endcase
        end
    end

    logic [PERIOD_W-1:0] per_eff;
    logic [PAL_CW-1:0]   cnt_eff;
    logic [SECLEN_W-1:0] len_eff;

    always_comb begin
        per_eff = (period_reg == '0) ? PERIOD_ZERO_MS : period_reg;
        if (count_reg == '0) begin
            cnt_eff = PAL_CW'(1);
        end else if (32'(count_reg) > 32'(PALETTE_DEPTH)) begin
            cnt_eff = PAL_CW'(PALETTE_DEPTH);
        end else begin
            cnt_eff = PAL_CW'(count_reg);
        end
        len_eff = (seclen_reg == '0) ? SECLEN_W'(DEFAULT_SECTION_LENGTH) : seclen_reg;
    end

    // phase and time state
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   last_adv_reg;
    logic [7:0]          phase_reg;
    logic [PERIOD_W-1:0] elapsed_reg;
    logic [TIME_W-1:0]   elapsed_raw;
    logic                period_done;

    assign elapsed_raw = now_reg - last_adv_reg;
    assign period_done = elapsed_raw >= TIME_W'(per_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_adv_reg <= '0;
            phase_reg    <= '0;
        end else if (cmd.eval_elapsed && period_done) begin
            last_adv_reg <= now_reg;
            phase_reg    <= phase_reg + 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept_tick) begin
            now_reg <= s_now_ms;
        end
        if (cmd.eval_elapsed) begin
            elapsed_reg <= period_done ? per_eff : elapsed_raw[PERIOD_W-1:0];
        end
    end

    // shared divider
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_quo;
    logic [DIV_DEN_W-1:0] div_rem;
    logic                 div_done;

    always_comb begin
        unique case (cmd.div_op)
            DIV_NSEC: begin
                div_num = DIV_NUM_W'(pixels_reg);
                div_den = DIV_DEN_W'(len_eff);
            end
            DIV_FRAC: begin
                div_num = {8'b0, elapsed_reg} * {16'b0, FRACTION_TOP};
                div_den = per_eff;
            end
            DIV_PHASE: begin
                div_num = DIV_NUM_W'(phase_reg);
                div_den = DIV_DEN_W'(cnt_eff);
            end
            default: begin
                div_num = DIV_NUM_W'(pixels_reg);
                div_den = DIV_DEN_W'(len_eff);
            end
        endcase
    end

    psf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num_in  (div_num),
        .den_in  (div_den),
        .quo_out (div_quo),
        .rem_out (div_rem),
        .done    (div_done)
    );

    // section walk
    logic [NSEC_W-1:0]  nsec_reg;
    logic [CHAN_W-1:0]  frac_reg;
    logic [NSEC_W-1:0]  sec_reg;
    logic [PIXEL_W-1:0] first_pix_reg;
    logic [PAL_AW-1:0]  cur_c_reg;
    logic [PAL_CW-1:0]  c_inc;
    logic [PAL_AW-1:0]  nxt_c;
    logic [NSEC_W-1:0]  sec_inc;

    assign c_inc   = PAL_CW'(cur_c_reg) + PAL_CW'(1);
    assign nxt_c   = (c_inc == cnt_eff) ? '0 : PAL_AW'(c_inc);
    assign sec_inc = sec_reg + NSEC_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.cap_nsec) begin
            nsec_reg <= (div_quo > DIV_NUM_W'(MAX_SECTIONS)) ? NSEC_W'(MAX_SECTIONS)
                                                              : NSEC_W'(div_quo);
        end
        if (cmd.cap_frac) begin
            frac_reg <= div_quo[CHAN_W-1:0];
        end
        if (cmd.cap_phase) begin
            cur_c_reg     <= PAL_AW'(div_rem);
            sec_reg       <= '0;
            first_pix_reg <= '0;
        end else if (cmd.advance) begin
            cur_c_reg     <= nxt_c;
            sec_reg       <= sec_inc;
            first_pix_reg <= first_pix_reg + PIXEL_W'(len_eff);
        end
    end

    // palette memory
    logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
    logic [COLOR_W-1:0] rd_a_reg;
    logic [COLOR_W-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (cmd.write_pal && 32'(s_entry_index) < 32'(PALETTE_DEPTH)) begin
            pal_mem[PAL_AW'(s_entry_index)] <= {s_red_in, s_green_in, s_blue_in};
        end
        if (cmd.read_pal) begin
            rd_a_reg <= pal_mem[cur_c_reg];
            rd_b_reg <= pal_mem[nxt_c];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_section_index <= SECIDX_W'(sec_reg);
            m_first_pixel   <= first_pix_reg;
            m_red   <= mix_chan(rd_a_reg[3*CHAN_W-1:2*CHAN_W],
                                rd_b_reg[3*CHAN_W-1:2*CHAN_W], frac_reg);
            m_green <= mix_chan(rd_a_reg[2*CHAN_W-1:CHAN_W],
                                rd_b_reg[2*CHAN_W-1:CHAN_W], frac_reg);
            m_blue  <= mix_chan(rd_a_reg[CHAN_W-1:0], rd_b_reg[CHAN_W-1:0], frac_reg);
            m_last  <= (sec_inc == nsec_reg);
        end
    end

    assign status.div_done  = div_done;
    assign status.nsec_zero = (nsec_reg == '0);
    assign status.last_sec  = m_last;

endmodule

/* rtl/core/palette_section_fade.sv */
// top level of the palette section fade block: controller plus datapath
// depends on psf_pkg, psf_ctrl, psf_dp
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  s_       | s_valid / s_ready      | cmd, now_ms, entry_index, red/green/blue_in
//  m_       | m_valid / m_ready      | section_index, first_pixel, red/green/blue, last
//  cfg_     | cfg_wr_en              | cfg_addr, cfg_wdata
//
// a palette write is taken from idle; a tick runs setup through three passes of the
// 24-step shared divider (section count, fraction, phase), then one palette read pair
// and a blend per section
// one item at a time: s_ready is low from a tick's acceptance to its last result
// m_ready low holds the current result and stretches the tick by the stall
// synchronous active-low reset returns to idle with phase and time cleared
module palette_section_fade #(
    parameter int MAX_SECTIONS           = 64,
    parameter int PALETTE_DEPTH          = 16,
    parameter int DEFAULT_SECTION_LENGTH = 3
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [psf_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [psf_pkg::CFG_DW-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [psf_pkg::TIME_W-1:0]    s_now_ms,
    input  logic [psf_pkg::ENTRY_W-1:0]   s_entry_index,
    input  logic [psf_pkg::CHAN_W-1:0]    s_red_in,
    input  logic [psf_pkg::CHAN_W-1:0]    s_green_in,
    input  logic [psf_pkg::CHAN_W-1:0]    s_blue_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [psf_pkg::SECIDX_W-1:0]  m_section_index,
    output logic [psf_pkg::PIXEL_W-1:0]   m_first_pixel,
    output logic [psf_pkg::CHAN_W-1:0]    m_red,
    output logic [psf_pkg::CHAN_W-1:0]    m_green,
    output logic [psf_pkg::CHAN_W-1:0]    m_blue,
    output logic                          m_last
);
    import psf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    psf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    psf_dp #(
        .MAX_SECTIONS           (MAX_SECTIONS),
        .PALETTE_DEPTH          (PALETTE_DEPTH),
        .DEFAULT_SECTION_LENGTH (DEFAULT_SECTION_LENGTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_now_ms        (s_now_ms),
        .s_entry_index   (s_entry_index),
        .s_red_in        (s_red_in),
        .s_green_in      (s_green_in),
        .s_blue_in       (s_blue_in),
        .cmd             (cmd),
        .status          (status),
        .m_section_index (m_section_index),
        .m_first_pixel   (m_first_pixel),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_last          (m_last)
    );

endmodule

/* rtl/core/psf_checker.sv */
// port-level checks for palette_section_fade, bound to the top level
// depends on palette_section_fade_defines.svh
`include "palette_section_fade_defines.svh"

module psf_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_cmd,
    input logic m_valid,
    input logic m_ready,
    input logic m_last
);

    `PSF_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid, "result dropped while stalled")
    `PSF_ASSERT_IMP(a_one_at_a_time, m_valid, !s_ready, "input taken while a result waits")
    `PSF_ASSERT_NXT(a_write_quiet, s_valid && s_ready && s_cmd, s_ready && !m_valid, "write item did not return to idle")
    `PSF_ASSERT_NXT(a_tick_busy, s_valid && s_ready && !s_cmd, !s_ready, "tick item did not start work")
    `PSF_ASSERT_NXT(a_more_sections, m_valid && m_ready && !m_last, !s_ready, "tick ended before last section")

endmodule

bind palette_section_fade psf_checker u_psf_checker (.*);

/* tb/tb_palette_section_fade.sv */
// self-checking testbench for palette_section_fade: directed and random palette writes
// and ticks; a scoreboard class predicts every section color and checks the m_ channel
// depends on psf_pkg and the palette_section_fade rtl
module tb_palette_section_fade;
    timeunit 1ns;
    timeprecision 1ps;
    import psf_pkg::*;

    localparam int MAX_SEC       = 64;
    localparam int PAL_DEPTH     = 16;
    localparam int DEF_LEN       = 3;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 800;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [SECIDX_W-1:0] section;
        logic [PIXEL_W-1:0]  first_pixel;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic                last;
    } section_color_t;

    class fade_scoreboard;
        logic [PERIOD_W-1:0] period;
        logic [COUNT_W-1:0]  color_count;
        logic [SECLEN_W-1:0] section_len;
        logic [PIXEL_W-1:0]  pixels;
        logic [COLOR_W-1:0]  palette [PAL_DEPTH];
        logic [7:0]          phase;
        logic [TIME_W-1:0]   advance_ms;
        section_color_t      expected_colors [$];
        int                  mismatches;

        function new();
            period      = RST_PERIOD;
            color_count = RST_COUNT;
            section_len = RST_SECLEN;
            pixels      = RST_PIXELS;
            foreach (palette[i]) palette[i] = '0;
            phase      = 8'd0;
            advance_ms = '0;
            mismatches = 0;
        endfunction

        function void write_reg(input cfg_reg_t addr, input logic [CFG_DW-1:0] value);
            case (addr)
                REG_PERIOD: period      = value[PERIOD_W-1:0];
                REG_COUNT:  color_count = value[COUNT_W-1:0];
                REG_SECLEN: section_len = value[SECLEN_W-1:0];
                REG_PIXELS: pixels      = value[PIXEL_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] a, b, f);
            int unsigned ua, ub, uf;
            ua = a;
            ub = b;
            uf = f;
            if (ub >= ua)
                return CHAN_W'(ua + (((ub - ua) * uf) >> 8));
            return CHAN_W'(ua - ((((ua - ub) * uf) + 255) >> 8));
        endfunction

        // palette write or tick; a tick queues one color per section
        function void note_item(input logic cmd, input logic [TIME_W-1:0] now,
                                input logic [ENTRY_W-1:0] entry,
                                input logic [CHAN_W-1:0] r, g, b);
            int unsigned per, cnt, len, nsec, frac, c, n;
            logic [TIME_W-1:0] elapsed;
            section_color_t col;
            if (cmd == CMD_WRITE) begin
                palette[entry] = {r, g, b};
                return;
            end
            per = (period == '0) ? 32'(PERIOD_ZERO_MS) : 32'(period);
            cnt = (color_count == '0) ? 1 : 32'(color_count);
            if (cnt > PAL_DEPTH) cnt = PAL_DEPTH;
            len = (section_len == '0) ? DEF_LEN : 32'(section_len);
            nsec = 32'(pixels) / len;
            if (nsec > MAX_SEC) nsec = MAX_SEC;
            elapsed = now - advance_ms;
            if (elapsed >= per) begin
                elapsed    = per;
                advance_ms = now;
                phase      = phase + 8'd1;
            end
            frac = (elapsed * 32'(FRACTION_TOP)) / per;
            for (int unsigned s = 0; s < nsec; s++) begin
                c = (32'(phase) + s) % cnt;
                n = (c + 1) % cnt;
                col.section     = SECIDX_W'(s);
                col.first_pixel = PIXEL_W'(s * len);
                col.red   = blend(palette[c][23:16], palette[n][23:16], CHAN_W'(frac));
                col.green = blend(palette[c][15:8], palette[n][15:8], CHAN_W'(frac));
                col.blue  = blend(palette[c][7:0], palette[n][7:0], CHAN_W'(frac));
                col.last  = (s + 1 == nsec);
                expected_colors.push_back(col);
            end
        endfunction

        function void check_color(input logic [SECIDX_W-1:0] sec,
                                  input logic [PIXEL_W-1:0] px,
                                  input logic [CHAN_W-1:0] r, g, b,
                                  input logic last);
            section_color_t want;
            if (expected_colors.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected color item: section %0d pixel %0d rgb %02h%02h%02h",
                             sec, px, r, g, b);
                return;
            end
            want = expected_colors.pop_front();
            if (sec !== want.section || px !== want.first_pixel || r !== want.red ||
                g !== want.green || b !== want.blue || last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("color mismatch: expected sec %0d px %0d rgb %02h%02h%02h last %0b, got sec %0d px %0d rgb %02h%02h%02h last %0b",
                             want.section, want.first_pixel, want.red, want.green,
                             want.blue, want.last, sec, px, r, g, b, last);
            end
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [CFG_AW-1:0]   cfg_addr;
    logic [CFG_DW-1:0]   cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic                s_cmd;
    logic [TIME_W-1:0]   s_now_ms;
    logic [ENTRY_W-1:0]  s_entry_index;
    logic [CHAN_W-1:0]   s_red_in;
    logic [CHAN_W-1:0]   s_green_in;
    logic [CHAN_W-1:0]   s_blue_in;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [SECIDX_W-1:0] m_section_index;
    logic [PIXEL_W-1:0]  m_first_pixel;
    logic [CHAN_W-1:0]   m_red;
    logic [CHAN_W-1:0]   m_green;
    logic [CHAN_W-1:0]   m_blue;
    logic                m_last;

    fade_scoreboard      board;
    int                  tx_idle_pct = 0;
    int                  rx_idle_pct = 34;
    int                  rx_hold_left = 0;
    int unsigned         cycles = 0;
    logic [TIME_W-1:0]   clock_ms;
    logic [PERIOD_W-1:0] cur_period;

    palette_section_fade #(
        .MAX_SECTIONS(MAX_SEC),
        .PALETTE_DEPTH(PAL_DEPTH),
        .DEFAULT_SECTION_LENGTH(DEF_LEN)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_now_ms(s_now_ms),
        .s_entry_index(s_entry_index),
        .s_red_in(s_red_in),
        .s_green_in(s_green_in),
        .s_blue_in(s_blue_in),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_section_index(m_section_index),
        .m_first_pixel(m_first_pixel),
        .m_red(m_red),
        .m_green(m_green),
        .m_blue(m_blue),
        .m_last(m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: check, then choose the next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_color(m_section_index, m_first_pixel, m_red, m_green, m_blue, m_last);
        if (rx_hold_left > 0) begin
            m_ready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input logic cmd, input logic [TIME_W-1:0] now,
                             input logic [ENTRY_W-1:0] entry,
                             input logic [CHAN_W-1:0] r, g, b);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_now_ms      <= now;
        s_entry_index <= entry;
        s_red_in      <= r;
        s_green_in    <= g;
        s_blue_in     <= b;
        do @(posedge aclk); while (!s_ready);
        board.note_item(cmd, now, entry, r, g, b);
    endtask

    task automatic send_tick(input logic [TIME_W-1:0] now);
        send_item(CMD_TICK, now, '0, '0, '0, '0);
    endtask

    // wait for all colors, then for any tick that gives none
    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input cfg_reg_t addr, input logic [CFG_DW-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        board.write_reg(addr, value);
        if (addr == REG_PERIOD) cur_period = value[PERIOD_W-1:0];
    endtask

    task automatic apply_config(input logic [CFG_DW-1:0] per, cnt, len, pix);
        drain();
        write_cfg(REG_PERIOD, per);
        write_cfg(REG_COUNT, cnt);
        write_cfg(REG_SECLEN, len);
        write_cfg(REG_PIXELS, pix);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [TIME_W-1:0] next_tick_time(input bit advance);
        int unsigned per, pick;
        per  = (cur_period == '0) ? 32'(PERIOD_ZERO_MS) : 32'(cur_period);
        pick = $urandom_range(0, 99);
        if (advance || pick < 45)
            clock_ms = clock_ms + per + $urandom_range(0, per / 2);
        else if (pick < 85)
            clock_ms = clock_ms + $urandom_range(0, per - 1);
        else if (pick < 95)
            clock_ms = $urandom();
        else
            clock_ms = clock_ms + per;
        return clock_ms;
    endfunction

    task automatic run_phase(input logic [CFG_DW-1:0] per, cnt, len, pix,
                             input int items, input int idle_pct,
                             input bit hold, input bit spin);
        apply_config(per, cnt, len, pix);
        tx_idle_pct = idle_pct;
        rx_idle_pct = idle_pct;
        for (int i = 0; i < items; i++) begin
            if (hold && i == items / 3) rx_hold_left = HOLD_CYCLES;
            if (!spin && $urandom_range(0, 3) == 0)
                send_item(CMD_WRITE, $urandom(), ENTRY_W'($urandom_range(0, 15)),
                          CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                          CHAN_W'($urandom_range(0, 255)));
            else
                send_item(CMD_TICK, next_tick_time(spin), ENTRY_W'($urandom_range(0, 15)),
                          CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                          CHAN_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        board = new();
        cur_period = RST_PERIOD;
        clock_ms   = '0;
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_addr      <= REG_PERIOD;
        cfg_wdata     <= '0;
        s_valid       <= 1'b0;
        s_cmd         <= CMD_TICK;
        s_now_ms      <= '0;
        s_entry_index <= '0;
        s_red_in      <= '0;
        s_green_in    <= '0;
        s_blue_in     <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 34;

        // fill the whole palette first so no tick reads an unwritten entry
        for (int i = 0; i < PAL_DEPTH; i++)
            send_item(CMD_WRITE, $urandom(), ENTRY_W'(i), CHAN_W'(i * 17),
                      CHAN_W'(255 - i * 17), (i % 2 == 1) ? 8'hff : 8'h00);
        send_tick(32'd0);

        // zero period, full palette, one-pixel sections saturating the count
        apply_config(16'd0, 16'd16, 16'd1, 16'd1023);
        send_tick(32'd49);
        send_tick(32'd100);

        // longest period, oversized count, widest sections, wrap of the time
        apply_config(16'hffff, 16'd31, 16'd255, 16'd1023);
        send_tick(32'hffff_fff0);
        send_tick(32'h0000_0010);

        // zero count and a strip shorter than one section
        apply_config(16'd1, 16'd0, 16'd200, 16'd199);
        send_tick(32'd5);

        apply_config(16'd3, 16'd2, 16'd10, 16'd1023);
        send_tick(32'd6);
        send_tick(32'd7);
        send_tick(32'd8);
        clock_ms = 32'd8;

        run_phase(16'd7, 16'd3, 16'd2, 16'd40, 25, 34, 1'b0, 1'b0);
        run_phase(16'd1, 16'd17, 16'd5, 16'd321, 25, 0, 1'b0, 1'b0);
        run_phase(16'd300, 16'd5, 16'd0, 16'd200, 30, 34, 1'b1, 1'b0);
        run_phase(16'hffff, 16'd16, 16'd255, 16'd1023, 15, 34, 1'b0, 1'b0);
        run_phase(CFG_DW'($urandom_range(0, 2000)), CFG_DW'($urandom_range(0, 31)),
                  CFG_DW'($urandom_range(0, 255)), CFG_DW'($urandom_range(0, 1023)),
                  35, 34, 1'b0, 1'b0);
        // many short ticks so the phase counter wraps
        run_phase(16'd0, 16'd3, 16'd3, 16'd6, 210, 34, 1'b0, 1'b1);

        drain();
        if (board.mismatches == 0 && board.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
